// File: hdl/assert_macros.svh
// Assertion macros shared by the route table RTL.
// Each macro checks a property on the rising edge of clk, with checking held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that must hold on every clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/dvrt_pkg.sv
// Package for the distance-vector route table: table constants, codes and shared types.
// It has no dependencies. The top level and dvrt_ctrl use it; dvrt_ram does not.
`default_nettype none
package dvrt_pkg;

    localparam int TABLE_DEPTH     = 64;
    localparam int CHUNK_ENTRIES   = 25;
    localparam int INTERFACE_COUNT = 4;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CHUNK_W = $clog2(CHUNK_ENTRIES + 1);

    localparam logic [4:0] INF_METRIC    = 5'd16;
    localparam logic [7:0] NEXT_HOP_MARK = 8'hff;
    localparam logic [7:0] METRIC_CAP    = 8'd15;

    localparam logic [1:0] OP_LEARN  = 2'd0;
    localparam logic [1:0] OP_DUMP   = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] OC_DUMP        = 3'd0;
    localparam logic [2:0] OC_IGNORED     = 3'd1;
    localparam logic [2:0] OC_REFRESHED   = 3'd2;
    localparam logic [2:0] OC_REPLACED    = 3'd3;
    localparam logic [2:0] OC_INSERTED    = 3'd4;
    localparam logic [2:0] OC_KEPT        = 3'd5;
    localparam logic [2:0] OC_UNREACHABLE = 3'd6;
    localparam logic [2:0] OC_FULL        = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_STATUS,
        ST_DUMP_RD,
        ST_DUMP_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] prefix_high;
        logic [63:0] prefix_low;
        logic [7:0]  prefix_length;
        logic [7:0]  metric_in;
        logic [15:0] tag_in;
        logic [63:0] neighbour_high;
        logic [63:0] neighbour_low;
        logic [1:0]  interface_req;
    } req_t;

    typedef struct packed {
        logic [63:0] prefix_high;
        logic [63:0] prefix_low;
        logic [7:0]  length;
        logic [1:0]  iface;
        logic [63:0] next_high;
        logic [63:0] next_low;
        logic [15:0] tag;
        logic [4:0]  metric;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic [63:0] entry_prefix_high;
        logic [63:0] entry_prefix_low;
        logic [7:0]  entry_length;
        logic [15:0] entry_tag;
        logic [4:0]  entry_metric;
        logic        chunk_end;
        logic        last;
        logic [2:0]  outcome;
    } rsp_t;

endpackage
`default_nettype wire

// File: hdl/distance_vector_route_table_unit.sv
// Top level of the distance-vector route table: request ports, sequencer and output register.
// Depends on dvrt_pkg, dvrt_ctrl and assert_macros.svh.
// Learn and insert: a scan of every slot (one slot read per cycle), then at most one write.
// Dump: reads each slot on the single read port and emits the live ones; no result if empty.
// One request at a time; the next is taken once the last result has left the sequencer.
// Reset (rst_n, async low) clears all valid bits at once; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module distance_vector_route_table_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [63:0] prefix_high,
    input  wire logic [63:0] prefix_low,
    input  wire logic [7:0]  prefix_length,
    input  wire logic [7:0]  metric_in,
    input  wire logic [15:0] tag_in,
    input  wire logic [63:0] neighbour_high,
    input  wire logic [63:0] neighbour_low,
    input  wire logic [1:0]  interface_req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [63:0]      entry_prefix_high,
    output logic [63:0]      entry_prefix_low,
    output logic [7:0]       entry_length,
    output logic [15:0]      entry_tag,
    output logic [4:0]       entry_metric,
    output logic             chunk_end,
    output logic             last,
    output logic [2:0]       outcome
);

    dvrt_pkg::req_t req;
    dvrt_pkg::rsp_t res, out_reg, out_next;
    logic           res_valid, res_stall;
    logic           ovld_reg, ovld_next;

    assign req.operation      = operation;
    assign req.prefix_high    = prefix_high;
    assign req.prefix_low     = prefix_low;
    assign req.prefix_length  = prefix_length;
    assign req.metric_in      = metric_in;
    assign req.tag_in         = tag_in;
    assign req.neighbour_high = neighbour_high;
    assign req.neighbour_low  = neighbour_low;
    assign req.interface_req  = interface_req;

    dvrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // output register: sequencer moves on as soon as the slot frees up
    assign res_stall = ovld_reg && rsp_stall;

    always_comb
    begin
        out_next  = out_reg;
        ovld_next = ovld_reg;
        if (res_valid && !res_stall)
        begin
            out_next  = res;
            ovld_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            ovld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else
        begin
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid         = ovld_reg;
    assign entry_prefix_high = out_reg.entry_prefix_high;
    assign entry_prefix_low  = out_reg.entry_prefix_low;
    assign entry_length      = out_reg.entry_length;
    assign entry_tag         = out_reg.entry_tag;
    assign entry_metric      = out_reg.entry_metric;
    assign chunk_end         = out_reg.chunk_end;
    assign last              = out_reg.last;
    assign outcome           = out_reg.outcome;

    `ASSERT_NEXT(a_result_lands, res_valid && !res_stall, ovld_reg, "handed result not registered")

endmodule
`default_nettype wire

// File: hdl/dvrt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// It has no dependencies.
`default_nettype none
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hdl/dvrt_ctrl.sv
// Route table sequencer: slot scan, update decision, write back and dump walk.
// Depends on dvrt_pkg, dvrt_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module dvrt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire dvrt_pkg::req_t req,
    output logic                res_valid,
    input  wire logic           res_stall,
    output dvrt_pkg::rsp_t      res
);

    dvrt_pkg::state_t state_reg, state_next;
    dvrt_pkg::req_t   req_reg, req_next;
    dvrt_pkg::slot_t  match_reg, match_next;
    dvrt_pkg::slot_t  rd_slot, wr_slot;

    logic [dvrt_pkg::CNT_W-1:0]     scan_reg, scan_next;
    logic [dvrt_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [dvrt_pkg::CNT_W-1:0]     emit_reg, emit_next;
    logic [dvrt_pkg::CHUNK_W-1:0]   chunk_reg, chunk_next;
    logic [dvrt_pkg::IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [dvrt_pkg::IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic [dvrt_pkg::IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [dvrt_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                           cmp_vld_reg, cmp_vld_next;
    logic                           found_reg, found_next;
    logic                           free_reg, free_next;
    logic [2:0]                     outcome_reg, outcome_next;

    logic [dvrt_pkg::IDX_W-1:0] idx;
    logic [dvrt_pkg::SLOT_W-1:0] rd_data;
    logic                       accept, emit, ignore_now, scan_done, slot_live, final_entry;
    logic                       we, new_slot, same_hop;
    logic [dvrt_pkg::IDX_W-1:0] widx;
    logic [2:0]                 decide_oc;
    logic [4:0]                 m_learn, m_insert;

    assign idx         = scan_reg[dvrt_pkg::IDX_W-1:0];
    assign rd_slot     = dvrt_pkg::slot_t'(rd_data);
    assign accept      = req_valid && !req_stall;
    assign scan_done   = scan_reg == dvrt_pkg::CNT_W'(dvrt_pkg::TABLE_DEPTH);
    assign slot_live   = valid_reg[idx];
    assign emit        = state_reg == dvrt_pkg::ST_DUMP_EMIT && slot_live && !res_stall;
    assign final_entry = (emit_reg + dvrt_pkg::CNT_W'(1)) == count_reg;
    assign same_hop    = match_reg.next_high == req_reg.neighbour_high &&
                         match_reg.next_low == req_reg.neighbour_low;

    // bypass the scan for requests that never touch the table
    assign ignore_now = req.operation == dvrt_pkg::OP_UNUSED ||
                        (req.operation != dvrt_pkg::OP_DUMP &&
                         int'(req.interface_req) >= dvrt_pkg::INTERFACE_COUNT) ||
                        (req.operation == dvrt_pkg::OP_LEARN &&
                         req.metric_in == dvrt_pkg::NEXT_HOP_MARK);

    assign m_learn  = (req_reg.metric_in >= dvrt_pkg::METRIC_CAP) ? dvrt_pkg::INF_METRIC :
                      req_reg.metric_in[4:0] + 5'd1;
    assign m_insert = (req_reg.metric_in > 8'(dvrt_pkg::INF_METRIC)) ? dvrt_pkg::INF_METRIC :
                      req_reg.metric_in[4:0];

    dvrt_ram #(
        .WIDTH (dvrt_pkg::SLOT_W),
        .DEPTH (dvrt_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (widx),
        .wdata (wr_slot),
        .raddr (idx),
        .rdata (rd_data)
    );

    // update decision, evaluated once the scan has finished
    always_comb
    begin
        we        = 1'b0;
        new_slot  = 1'b0;
        widx      = match_idx_reg;
        decide_oc = dvrt_pkg::OC_IGNORED;
        wr_slot.prefix_high = req_reg.prefix_high;
        wr_slot.prefix_low  = req_reg.prefix_low;
        wr_slot.length      = req_reg.prefix_length;
        wr_slot.iface       = req_reg.interface_req;
        wr_slot.next_high   = req_reg.neighbour_high;
        wr_slot.next_low    = req_reg.neighbour_low;
        wr_slot.tag         = req_reg.tag_in;
        wr_slot.metric      = m_learn;
        if (req_reg.operation == dvrt_pkg::OP_INSERT)
        begin
            wr_slot.next_high = 64'd0;
            wr_slot.next_low  = 64'd0;
            wr_slot.metric    = m_insert;
            if (found_reg)
            begin
                we        = 1'b1;
                decide_oc = dvrt_pkg::OC_REPLACED;
            end
            else if (free_reg)
            begin
                we        = 1'b1;
                new_slot  = 1'b1;
                widx      = free_idx_reg;
                decide_oc = dvrt_pkg::OC_INSERTED;
            end
            else
            begin
                decide_oc = dvrt_pkg::OC_FULL;
            end
        end
        else if (found_reg)
        begin
            if (same_hop)
            begin
                we          = 1'b1;
                wr_slot.tag = match_reg.tag;
                decide_oc   = dvrt_pkg::OC_REFRESHED;
            end
            else if (m_learn < match_reg.metric)
            begin
                we        = 1'b1;
                decide_oc = dvrt_pkg::OC_REPLACED;
            end
            else
            begin
                decide_oc = dvrt_pkg::OC_KEPT;
            end
        end
        else if (m_learn >= dvrt_pkg::INF_METRIC)
        begin
            decide_oc = dvrt_pkg::OC_UNREACHABLE;
        end
        else if (free_reg)
        begin
            we        = 1'b1;
            new_slot  = 1'b1;
            widx      = free_idx_reg;
            decide_oc = dvrt_pkg::OC_INSERTED;
        end
        else
        begin
            decide_oc = dvrt_pkg::OC_FULL;
        end
        if (state_reg != dvrt_pkg::ST_DECIDE)
        begin
            we       = 1'b0;
            new_slot = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dvrt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.operation == dvrt_pkg::OP_DUMP)
                    begin
                        state_next = (count_reg == '0) ? dvrt_pkg::ST_IDLE : dvrt_pkg::ST_DUMP_RD;
                    end
                    else if (ignore_now)
                    begin
                        state_next = dvrt_pkg::ST_STATUS;
                    end
                    else
                    begin
                        state_next = dvrt_pkg::ST_SCAN;
                    end
                end
            end
            dvrt_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = dvrt_pkg::ST_DECIDE;
                end
            end
            dvrt_pkg::ST_DECIDE:
            begin
                state_next = dvrt_pkg::ST_STATUS;
            end
            dvrt_pkg::ST_STATUS:
            begin
                if (!res_stall)
                begin
                    state_next = dvrt_pkg::ST_IDLE;
                end
            end
            dvrt_pkg::ST_DUMP_RD:
            begin
                state_next = dvrt_pkg::ST_DUMP_EMIT;
            end
            dvrt_pkg::ST_DUMP_EMIT:
            begin
                if (!slot_live)
                begin
                    state_next = dvrt_pkg::ST_DUMP_RD;
                end
                else if (!res_stall)
                begin
                    state_next = final_entry ? dvrt_pkg::ST_IDLE : dvrt_pkg::ST_DUMP_RD;
                end
            end
            default:
            begin
                state_next = dvrt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_stall = state_reg != dvrt_pkg::ST_IDLE;
        res_valid = 1'b0;
        res       = '0;
        case (state_reg)
            dvrt_pkg::ST_STATUS:
            begin
                res_valid   = 1'b1;
                res.last    = 1'b1;
                res.outcome = outcome_reg;
            end
            dvrt_pkg::ST_DUMP_EMIT:
            begin
                res_valid             = slot_live;
                res.entry_prefix_high = rd_slot.prefix_high;
                res.entry_prefix_low  = rd_slot.prefix_low;
                res.entry_length      = rd_slot.length;
                res.entry_tag         = rd_slot.tag;
                res.entry_metric      = (rd_slot.iface == req_reg.interface_req) ?
                                        dvrt_pkg::INF_METRIC : rd_slot.metric;
                res.chunk_end         = final_entry ||
                    chunk_reg == dvrt_pkg::CHUNK_W'(dvrt_pkg::CHUNK_ENTRIES - 1);
                res.last              = final_entry;
                res.outcome           = dvrt_pkg::OC_DUMP;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        req_next       = req_reg;
        scan_next      = scan_reg;
        count_next     = count_reg;
        emit_next      = emit_reg;
        chunk_next     = chunk_reg;
        valid_next     = valid_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        free_idx_next  = free_idx_reg;
        outcome_next   = outcome_reg;
        cmp_vld_next   = state_reg == dvrt_pkg::ST_SCAN && !scan_done;
        cmp_idx_next   = idx;

        if (accept)
        begin
            req_next     = req;
            scan_next    = '0;
            emit_next    = '0;
            chunk_next   = '0;
            found_next   = 1'b0;
            free_next    = 1'b0;
            outcome_next = dvrt_pkg::OC_IGNORED;
        end

        if (state_reg == dvrt_pkg::ST_SCAN && !scan_done)
        begin
            scan_next = scan_reg + dvrt_pkg::CNT_W'(1);
        end

        // compare the slot read in the previous cycle
        if (cmp_vld_reg)
        begin
            if (valid_reg[cmp_idx_reg])
            begin
                if (!found_reg && rd_slot.prefix_high == req_reg.prefix_high &&
                    rd_slot.prefix_low == req_reg.prefix_low &&
                    rd_slot.length == req_reg.prefix_length)
                begin
                    found_next     = 1'b1;
                    match_idx_next = cmp_idx_reg;
                    match_next     = rd_slot;
                end
            end
            else if (!free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx_reg;
            end
        end

        if (state_reg == dvrt_pkg::ST_DECIDE)
        begin
            outcome_next = decide_oc;
            if (we)
            begin
                valid_next[widx] = 1'b1;
            end
            if (new_slot)
            begin
                count_next = count_reg + dvrt_pkg::CNT_W'(1);
            end
        end

        if (state_reg == dvrt_pkg::ST_DUMP_EMIT && (!slot_live || !res_stall))
        begin
            scan_next = scan_reg + dvrt_pkg::CNT_W'(1);
        end
        if (emit)
        begin
            emit_next  = emit_reg + dvrt_pkg::CNT_W'(1);
            chunk_next = (chunk_reg == dvrt_pkg::CHUNK_W'(dvrt_pkg::CHUNK_ENTRIES - 1)) ?
                         '0 : chunk_reg + dvrt_pkg::CHUNK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dvrt_pkg::ST_IDLE;
            valid_reg   <= '0;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        scan_reg      <= scan_next;
        emit_reg      <= emit_next;
        chunk_reg     <= chunk_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_reg     <= found_next;
        free_reg      <= free_next;
        match_reg     <= match_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        outcome_reg   <= outcome_next;
    end

    `ASSERT_CLK(a_count_tracks_valid, count_reg == dvrt_pkg::CNT_W'($countones(valid_reg)), "route count out of step with valid bits")
    `ASSERT_CLK(a_no_result_when_idle, !req_stall |-> !res_valid, "result offered while idle")
    `ASSERT_NEXT(a_write_only_once, we, !we, "table written on two cycles in a row")

endmodule
`default_nettype wire
